// ===== design/fpc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpc_pkg: shared types and constants for the frustum primitive cull block
// Primitive codes, register indexes, field layout and pipeline control types.
// ----------------------------------------------------------------------------
package fpc_pkg;

    localparam int DEF_EPSILON     = 1;
    localparam int DEF_COORD_WIDTH = 16;

    localparam int NUM_PLANES = 6;
    localparam int NUM_PTS    = 3;
    localparam int NUM_AXES   = 3;
    localparam int FIELD_W    = 16;
    localparam int PLANE_W    = 64;
    localparam int BOX_W      = 48;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int OFF_LSB    = 48;

    // offset scaling to 14 fraction bits: x1 for points, x2 for doubled box
    localparam int PT_SHIFT  = 14;
    localparam int BOX_SHIFT = 15;

    typedef enum logic [1:0] {
        FUNC_BOX      = 2'd0,
        FUNC_POINT    = 2'd1,
        FUNC_SEGMENT  = 2'd2,
        FUNC_TRIANGLE = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLANE_A  = 3'd0,
        REG_PLANE_B  = 3'd1,
        REG_PLANE_C  = 3'd2,
        REG_PLANE_D  = 3'd3,
        REG_PLANE_E  = 3'd4,
        REG_PLANE_F  = 3'd5,
        REG_BOX_MIN  = 3'd6,
        REG_BOX_MAX  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } t_stage_en;

endpackage

// ===== design/fpc_prep.sv =====
// ----------------------------------------------------------------------------
// fpc_prep: input register stage
// Selects multiplier operands per primitive kind (box centre and extent are
// doubled as max+min and max-min) and registers the frustum box overlap flag.
// ----------------------------------------------------------------------------
module fpc_prep #(
    parameter int COORD_WIDTH = fpc_pkg::DEF_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  fpc_pkg::t_stage_en            i_en,
    input  fpc_pkg::t_func                i_func,
    input  logic signed [COORD_WIDTH-1:0] i_pt [fpc_pkg::NUM_PTS][fpc_pkg::NUM_AXES],
    input  logic [fpc_pkg::BOX_W-1:0]     i_fbox_min,
    input  logic [fpc_pkg::BOX_W-1:0]     i_fbox_max,
    output fpc_pkg::t_func                o_func,
    output logic signed [COORD_WIDTH:0]   o_op [fpc_pkg::NUM_PTS][fpc_pkg::NUM_AXES],
    output logic                          o_ov
);

    localparam int MW   = COORD_WIDTH + 1;
    localparam int CMPW = (COORD_WIDTH > fpc_pkg::FIELD_W) ? COORD_WIDTH : fpc_pkg::FIELD_W;

    logic signed [MW-1:0] n_op [fpc_pkg::NUM_PTS][fpc_pkg::NUM_AXES];
    logic                 n_ov;
    logic signed [MW-1:0] r_op [fpc_pkg::NUM_PTS][fpc_pkg::NUM_AXES];
    fpc_pkg::t_func       r_func;
    logic                 r_ov;

    always_comb begin
        for (int j = 0; j < fpc_pkg::NUM_AXES; j++) begin
            if (i_func == fpc_pkg::FUNC_BOX) begin
                n_op[0][j] = MW'(i_pt[1][j]) + MW'(i_pt[0][j]);
                n_op[1][j] = MW'(i_pt[1][j]) - MW'(i_pt[0][j]);
            end else begin
                n_op[0][j] = MW'(i_pt[0][j]);
                n_op[1][j] = MW'(i_pt[1][j]);
            end
            n_op[2][j] = MW'(i_pt[2][j]);
        end
    end

    always_comb begin
        logic signed [CMPW-1:0] fmn;
        logic signed [CMPW-1:0] fmx;
        logic signed [CMPW-1:0] pmn;
        logic signed [CMPW-1:0] pmx;
        n_ov = 1'b1;
        for (int j = 0; j < fpc_pkg::NUM_AXES; j++) begin
            fmn = CMPW'(signed'(i_fbox_min[fpc_pkg::FIELD_W*j +: fpc_pkg::FIELD_W]));
            fmx = CMPW'(signed'(i_fbox_max[fpc_pkg::FIELD_W*j +: fpc_pkg::FIELD_W]));
            pmn = CMPW'(i_pt[0][j]);
            pmx = CMPW'(i_pt[1][j]);
            if (!(((pmn >= fmn) && (pmn <= fmx)) || ((fmn >= pmn) && (fmn <= pmx)))) begin
                n_ov = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld1) begin
            r_op   <= n_op;
            r_func <= i_func;
            r_ov   <= n_ov;
        end
    end

    assign o_op   = r_op;
    assign o_func = r_func;
    assign o_ov   = r_ov;

endmodule

// ===== design/fpc_plane.sv =====
// ----------------------------------------------------------------------------
// fpc_plane: one frustum plane test
// Product stage, sum stage (distances and box radius), then the behind
// decision for the primitive kind held in the sum stage.
// ----------------------------------------------------------------------------
module fpc_plane #(
    parameter int COORD_WIDTH = fpc_pkg::DEF_COORD_WIDTH,
    parameter int EPSILON     = fpc_pkg::DEF_EPSILON
) (
    input  logic                          i_clk,
    input  fpc_pkg::t_stage_en            i_en,
    input  logic [fpc_pkg::PLANE_W-1:0]   i_plane,
    input  logic signed [COORD_WIDTH:0]   i_op [fpc_pkg::NUM_PTS][fpc_pkg::NUM_AXES],
    input  fpc_pkg::t_func                i_func_s2,
    input  fpc_pkg::t_func                i_func_s3,
    output logic                          o_behind
);

    localparam int PW = COORD_WIDTH + 17;
    localparam int SW = COORD_WIDTH + 22;
    localparam logic signed [SW-1:0] EPS_PT  = SW'(EPSILON * (1 << fpc_pkg::PT_SHIFT));
    localparam logic signed [SW-1:0] EPS_BOX = SW'(EPSILON * (1 << fpc_pkg::BOX_SHIFT));

    logic signed [fpc_pkg::FIELD_W-1:0] w_norm [fpc_pkg::NUM_AXES];
    logic signed [fpc_pkg::FIELD_W-1:0] w_off;

    logic signed [PW-1:0] r_prod [fpc_pkg::NUM_PTS][fpc_pkg::NUM_AXES];
    logic signed [SW-1:0] n_dist [fpc_pkg::NUM_PTS];
    logic signed [SW-1:0] n_rad;
    logic signed [SW-1:0] r_dist [fpc_pkg::NUM_PTS];
    logic signed [SW-1:0] r_rad;

    logic                 w_pb [fpc_pkg::NUM_PTS];
    logic signed [SW-1:0] w_dmr;
    logic signed [SW-1:0] w_abs_dmr;
    logic signed [SW-1:0] w_abs_d;
    logic                 w_box_b;

    always_comb begin
        for (int j = 0; j < fpc_pkg::NUM_AXES; j++) begin
            w_norm[j] = signed'(i_plane[fpc_pkg::FIELD_W*j +: fpc_pkg::FIELD_W]);
        end
        w_off = signed'(i_plane[fpc_pkg::OFF_LSB +: fpc_pkg::FIELD_W]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld2) begin
            for (int i = 0; i < fpc_pkg::NUM_PTS; i++) begin
                for (int j = 0; j < fpc_pkg::NUM_AXES; j++) begin
                    r_prod[i][j] <= PW'(w_norm[j]) * PW'(i_op[i][j]);
                end
            end
        end
    end

    always_comb begin
        logic signed [SW-1:0] off_pt;
        logic signed [SW-1:0] off_box;
        logic signed [SW-1:0] a;
        off_pt  = SW'(w_off) <<< fpc_pkg::PT_SHIFT;
        off_box = SW'(w_off) <<< fpc_pkg::BOX_SHIFT;
        for (int i = 0; i < fpc_pkg::NUM_PTS; i++) begin
            n_dist[i] = SW'(r_prod[i][0]) + SW'(r_prod[i][1]) + SW'(r_prod[i][2]);
            if ((i == 0) && (i_func_s2 == fpc_pkg::FUNC_BOX)) begin
                n_dist[i] = n_dist[i] + off_box;
            end else begin
                n_dist[i] = n_dist[i] + off_pt;
            end
        end
        // row 1 holds n * (max - min) for a box
        n_rad = '0;
        for (int j = 0; j < fpc_pkg::NUM_AXES; j++) begin
            a     = SW'(r_prod[1][j]);
            n_rad = n_rad + ((a < 0) ? -a : a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld3) begin
            r_dist <= n_dist;
            r_rad  <= n_rad;
        end
    end

    always_comb begin
        for (int i = 0; i < fpc_pkg::NUM_PTS; i++) begin
            w_pb[i] = r_dist[i] < -EPS_PT;
        end
        w_dmr     = r_dist[0] - r_rad;
        w_abs_dmr = (w_dmr < 0) ? -w_dmr : w_dmr;
        w_abs_d   = (r_dist[0] < 0) ? -r_dist[0] : r_dist[0];
        w_box_b   = (r_dist[0] < 0) && (w_abs_dmr > EPS_BOX) && (w_abs_d >= r_rad - EPS_BOX);
    end

    always_comb begin
        unique case (i_func_s3)
            fpc_pkg::FUNC_BOX:      o_behind = w_box_b;
            fpc_pkg::FUNC_POINT:    o_behind = w_pb[0];
            fpc_pkg::FUNC_SEGMENT:  o_behind = w_pb[0] && w_pb[1];
            fpc_pkg::FUNC_TRIANGLE: o_behind = w_pb[0] && w_pb[1] && w_pb[2];
            default:                o_behind = 1'b0;
        endcase
    end

endmodule

// ===== design/frustum_primitive_cull.sv =====
// ----------------------------------------------------------------------------
// frustum_primitive_cull: view frustum culling of boxes, points, segments
// and triangles against six planes and the frustum bounding box.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+----------------------------------
//   input    | in  | i_valid / o_ready  | i_func, i_ax .. i_cz
//   result   | out | o_valid / i_ready  | o_visible
//   config   | in  | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// One word accepted per cycle while o_ready is high; each word passes the
// input register at the accepting edge, then the product register, sum
// register and result register.
// Each stage has its own valid bit and loads when empty or draining, so
// bubbles close up behind a held result; only when every stage is full does a held result stall the input.
// Synchronous reset clears valid bits and all config registers to zero.
// ----------------------------------------------------------------------------
module frustum_primitive_cull #(
    parameter int EPSILON     = fpc_pkg::DEF_EPSILON,
    parameter int COORD_WIDTH = fpc_pkg::DEF_COORD_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_func,
    input  logic signed [COORD_WIDTH-1:0]   i_ax,
    input  logic signed [COORD_WIDTH-1:0]   i_ay,
    input  logic signed [COORD_WIDTH-1:0]   i_az,
    input  logic signed [COORD_WIDTH-1:0]   i_bx,
    input  logic signed [COORD_WIDTH-1:0]   i_by_coord,
    input  logic signed [COORD_WIDTH-1:0]   i_bz,
    input  logic signed [COORD_WIDTH-1:0]   i_cx,
    input  logic signed [COORD_WIDTH-1:0]   i_cy,
    input  logic signed [COORD_WIDTH-1:0]   i_cz,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_visible,
    input  logic                            i_cfg_we,
    input  logic [fpc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fpc_pkg::CFG_W-1:0]       i_cfg_data
);

    logic [fpc_pkg::PLANE_W-1:0] r_plane [fpc_pkg::NUM_PLANES];
    logic [fpc_pkg::BOX_W-1:0]   r_fbox_min;
    logic [fpc_pkg::BOX_W-1:0]   r_fbox_max;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_out_valid;
    logic r_visible;
    logic n_visible;

    fpc_pkg::t_func r_func2;
    fpc_pkg::t_func r_func3;
    logic           r_ov2;
    logic           r_ov3;

    fpc_pkg::t_stage_en w_en;
    logic               w_ld_out;

    logic signed [COORD_WIDTH-1:0] w_pt [fpc_pkg::NUM_PTS][fpc_pkg::NUM_AXES];
    logic signed [COORD_WIDTH:0]   w_op [fpc_pkg::NUM_PTS][fpc_pkg::NUM_AXES];
    fpc_pkg::t_func                w_func1;
    logic                          w_ov1;
    logic [fpc_pkg::NUM_PLANES-1:0] w_behind;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < fpc_pkg::NUM_PLANES; k++) begin
                r_plane[k] <= '0;
            end
            r_fbox_min <= '0;
            r_fbox_max <= '0;
        end else if (i_cfg_we) begin
            unique case (fpc_pkg::t_reg_idx'(i_cfg_idx))
                fpc_pkg::REG_PLANE_A: r_plane[0] <= i_cfg_data;
                fpc_pkg::REG_PLANE_B: r_plane[1] <= i_cfg_data;
                fpc_pkg::REG_PLANE_C: r_plane[2] <= i_cfg_data;
                fpc_pkg::REG_PLANE_D: r_plane[3] <= i_cfg_data;
                fpc_pkg::REG_PLANE_E: r_plane[4] <= i_cfg_data;
                fpc_pkg::REG_PLANE_F: r_plane[5] <= i_cfg_data;
                fpc_pkg::REG_BOX_MIN: r_fbox_min <= i_cfg_data[fpc_pkg::BOX_W-1:0];
                fpc_pkg::REG_BOX_MAX: r_fbox_max <= i_cfg_data[fpc_pkg::BOX_W-1:0];
                default: ;
            endcase
        end
    end

    // stage load enables
    always_comb begin
        w_ld_out = !r_out_valid || i_ready;
        w_en.ld3 = !r_v3 || w_ld_out;
        w_en.ld2 = !r_v2 || w_en.ld3;
        w_en.ld1 = !r_v1 || w_en.ld2;
    end

    assign o_ready = w_en.ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en.ld1) r_v1 <= i_valid;
            if (w_en.ld2) r_v2 <= r_v1;
            if (w_en.ld3) r_v3 <= r_v2;
            if (w_ld_out) r_out_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en.ld2) begin
            r_func2 <= w_func1;
            r_ov2   <= w_ov1;
        end
        if (w_en.ld3) begin
            r_func3 <= r_func2;
            r_ov3   <= r_ov2;
        end
        if (w_ld_out) begin
            r_visible <= n_visible;
        end
    end

    always_comb begin
        w_pt[0][0] = i_ax;
        w_pt[0][1] = i_ay;
        w_pt[0][2] = i_az;
        w_pt[1][0] = i_bx;
        w_pt[1][1] = i_by_coord;
        w_pt[1][2] = i_bz;
        w_pt[2][0] = i_cx;
        w_pt[2][1] = i_cy;
        w_pt[2][2] = i_cz;
    end

    fpc_prep #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prep (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_func     (fpc_pkg::t_func'(i_func)),
        .i_pt       (w_pt),
        .i_fbox_min (r_fbox_min),
        .i_fbox_max (r_fbox_max),
        .o_func     (w_func1),
        .o_op       (w_op),
        .o_ov       (w_ov1)
    );

    for (genvar k = 0; k < fpc_pkg::NUM_PLANES; k++) begin : g_plane
        fpc_plane #(
            .COORD_WIDTH (COORD_WIDTH),
            .EPSILON     (EPSILON)
        ) u_plane (
            .i_clk     (i_clk),
            .i_en      (w_en),
            .i_plane   (r_plane[k]),
            .i_op      (w_op),
            .i_func_s2 (r_func2),
            .i_func_s3 (r_func3),
            .o_behind  (w_behind[k])
        );
    end

    assign n_visible = !(|w_behind) && ((r_func3 != fpc_pkg::FUNC_BOX) || r_ov3);

    assign o_valid   = r_out_valid;
    assign o_visible = r_visible;

endmodule

// ===== tb/tb_frustum_primitive_cull.sv =====
// ----------------------------------------------------------------------------
// tb_frustum_primitive_cull: self-checking bench for the frustum cull block
// Boxes, points, segments and triangles are pushed through the valid/ready
// input while the result side stalls at random. A scoreboard predicts each
// visible bit from its own copy of the six planes and the frustum bounding
// box. Several register settings are loaded while the block is idle: reset
// values, an axis-aligned cube, random inward planes, fully random words,
// field extremes and a cube with an inverted frustum box.
// ----------------------------------------------------------------------------
module tb_frustum_primitive_cull;
    import fpc_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          MAX_REPORTS    = 10;
    localparam longint      EPS            = DEF_EPSILON;
    localparam int          CUBE_HALF      = 'h400;
    localparam int          FBOX_HALF      = 'h3C0;
    localparam logic [15:0] CUBE_OFF       = 16'h0400;
    localparam logic [15:0] N_POS          = 16'h4000;
    localparam logic [15:0] N_NEG          = 16'hC000;

    // c[0..2] = a (box min), c[3..5] = b (box max), c[6..8] = c
    typedef struct packed {
        t_func            func;
        logic [8:0][15:0] c;
    } t_prim;

    class cull_board;
        logic [PLANE_W-1:0] plane_reg [NUM_PLANES];
        logic [BOX_W-1:0]   fbox_min;
        logic [BOX_W-1:0]   fbox_max;
        bit                 visible_q [$];
        int                 mismatches;
        int                 checked;
        int                 n_visible;

        function new();
            foreach (plane_reg[k]) plane_reg[k] = '0;
            fbox_min   = '0;
            fbox_max   = '0;
            mismatches = 0;
            checked    = 0;
            n_visible  = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_BOX_MIN: fbox_min = data[BOX_W-1:0];
                REG_BOX_MAX: fbox_max = data[BOX_W-1:0];
                default:     plane_reg[int'(idx)] = data;
            endcase
        endfunction

        function bit predict_visible(t_prim p);
            longint q [NUM_PTS][NUM_AXES];
            longint n [NUM_AXES];
            longint off, d, r, t, lo, hi, pt_scale, box_scale;
            bit     vis, back;
            vis       = 1'b1;
            pt_scale  = longint'(1) << PT_SHIFT;
            box_scale = longint'(1) << BOX_SHIFT;
            for (int k = 0; k < NUM_PTS; k++)
                for (int a = 0; a < NUM_AXES; a++)
                    q[k][a] = $signed(p.c[k*NUM_AXES + a]);
            for (int k = 0; k < NUM_PLANES; k++) begin
                for (int a = 0; a < NUM_AXES; a++)
                    n[a] = $signed(plane_reg[k][a*FIELD_W +: FIELD_W]);
                off = $signed(plane_reg[k][OFF_LSB +: FIELD_W]);
                if (p.func == FUNC_BOX) begin
                    // doubled centre distance and doubled half extent
                    d = off * box_scale;
                    r = 0;
                    for (int a = 0; a < NUM_AXES; a++) begin
                        d = d + n[a] * (q[0][a] + q[1][a]);
                        t = n[a] * (q[1][a] - q[0][a]);
                        r = r + ((t < 0) ? -t : t);
                    end
                    t = d - r;
                    back = (d < 0) && (((t < 0) ? -t : t) > EPS * box_scale)
                        && (-d >= r - EPS * box_scale);
                end else begin
                    back = 1'b1;
                    for (int i = 0; i < int'(p.func); i++) begin
                        d = n[0] * q[i][0] + n[1] * q[i][1] + n[2] * q[i][2]
                          + off * pt_scale;
                        if (d >= -(EPS * pt_scale))
                            back = 1'b0;
                    end
                end
                if (back)
                    vis = 1'b0;
            end
            if (p.func == FUNC_BOX) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    lo = $signed(fbox_min[a*FIELD_W +: FIELD_W]);
                    hi = $signed(fbox_max[a*FIELD_W +: FIELD_W]);
                    if (!((q[0][a] >= lo && q[0][a] <= hi) ||
                          (lo >= q[0][a] && lo <= q[1][a])))
                        vis = 1'b0;
                end
            end
            return vis;
        endfunction

        function void note_primitive(t_prim p);
            visible_q.push_back(predict_visible(p));
        endfunction

        function void check_visible(logic got);
            bit want;
            if (visible_q.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result word at %0t: visible=%b", $time, got);
                mismatches++;
                return;
            end
            want = visible_q.pop_front();
            checked++;
            if (got !== want) begin
                if (mismatches < MAX_REPORTS)
                    $display("visible mismatch at %0t: expected %b, got %b",
                             $time, want, got);
                mismatches++;
            end else if (want) begin
                n_visible++;
            end
        endfunction

        function int pending();
            return visible_q.size();
        endfunction
    endclass

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_valid    = 1'b0;
    logic                   o_ready;
    logic [1:0]             i_func     = '0;
    logic signed [15:0]     i_ax       = '0;
    logic signed [15:0]     i_ay       = '0;
    logic signed [15:0]     i_az       = '0;
    logic signed [15:0]     i_bx       = '0;
    logic signed [15:0]     i_by_coord = '0;
    logic signed [15:0]     i_bz       = '0;
    logic signed [15:0]     i_cx       = '0;
    logic signed [15:0]     i_cy       = '0;
    logic signed [15:0]     i_cz       = '0;
    logic                   o_valid;
    logic                   i_ready    = 1'b0;
    logic                   o_visible;
    logic                   i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx  = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;

    cull_board board;
    bit        idle_on;
    int        rx_stall_left   = 0;
    int        watchdog_cycles = 0;
    int        sent_by_func [4] = '{0, 0, 0, 0};

    frustum_primitive_cull u_top (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                board.check_visible(o_visible);
            if (rx_stall_left > 0) begin
                rx_stall_left--;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                rx_stall_left = $urandom_range(0, 13);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we)
            watchdog_cycles = 0;
        else
            watchdog_cycles++;
        if (watchdog_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_prim mk_prim(t_func f, int ax, int ay, int az, int bx,
                                      int by_c, int bz, int cx, int cy, int cz);
        t_prim p;
        p.func = f;
        p.c = {cz[15:0], cy[15:0], cx[15:0], bz[15:0], by_c[15:0], bx[15:0],
               az[15:0], ay[15:0], ax[15:0]};
        return p;
    endfunction

    function automatic logic [15:0] rand_coord(int span);
        int v;
        case ($urandom_range(0, 7))
            0: v = $urandom();
            1: v = (($urandom_range(0, 1) != 0) ? CUBE_HALF : FBOX_HALF)
                 * (($urandom_range(0, 1) != 0) ? 1 : -1)
                 + int'($urandom_range(0, 6)) - 3;
            default: v = int'($urandom_range(0, 2 * span)) - span;
        endcase
        return v[15:0];
    endfunction

    function automatic t_prim gen_prim(int span);
        t_prim p;
        int    sel;
        int    v;
        p.func = t_func'($urandom_range(0, 3));
        for (int i = 0; i < 9; i++)
            p.c[i] = rand_coord(span);
        sel = $urandom_range(0, 9);
        if (p.func == FUNC_BOX) begin
            // mostly well-ordered boxes, the rest inverted or arbitrary
            if (sel != 0)
                for (int a = 0; a < NUM_AXES; a++) begin
                    v = int'($signed(p.c[a])) + int'($urandom_range(0, span));
                    p.c[3 + a] = v[15:0];
                end
        end else if (sel < 4) begin
            // cluster points b and c around point a, so that all of them can fall behind one plane
            for (int i = 3; i < 9; i++) begin
                v = int'($signed(p.c[i % 3])) + int'($urandom_range(0, 64)) - 32;
                p.c[i] = v[15:0];
            end
        end
        return p;
    endfunction

    task automatic send_prim(t_prim p);
        i_valid    <= 1'b1;
        i_func     <= p.func;
        i_ax       <= p.c[0];
        i_ay       <= p.c[1];
        i_az       <= p.c[2];
        i_bx       <= p.c[3];
        i_by_coord <= p.c[4];
        i_bz       <= p.c[5];
        i_cx       <= p.c[6];
        i_cy       <= p.c[7];
        i_cz       <= p.c[8];
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        board.note_primitive(p);
        sent_by_func[int'(p.func)]++;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic run_random(int count, int span, bit quiet);
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 0)
                idle_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
            send_prim(gen_prim(span));
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_reg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // axis-aligned cube |x|,|y|,|z| <= CUBE_HALF; normals point inward
    task automatic set_cube(int bmin, int bmax);
        write_cfg(REG_PLANE_A, {CUBE_OFF, 16'h0000, 16'h0000, N_POS});
        write_cfg(REG_PLANE_B, {CUBE_OFF, 16'h0000, 16'h0000, N_NEG});
        write_cfg(REG_PLANE_C, {CUBE_OFF, 16'h0000, N_POS, 16'h0000});
        write_cfg(REG_PLANE_D, {CUBE_OFF, 16'h0000, N_NEG, 16'h0000});
        write_cfg(REG_PLANE_E, {CUBE_OFF, N_POS, 16'h0000, 16'h0000});
        write_cfg(REG_PLANE_F, {CUBE_OFF, N_NEG, 16'h0000, 16'h0000});
        write_cfg(REG_BOX_MIN, {16'h0000, bmin[15:0], bmin[15:0], bmin[15:0]});
        write_cfg(REG_BOX_MAX, {16'h0000, bmax[15:0], bmax[15:0], bmax[15:0]});
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_random_frustum(bit inward);
        logic [15:0] f [4];
        logic [15:0] g [3];
        int          v;
        for (int k = 0; k < NUM_PLANES; k++) begin
            for (int j = 0; j < 4; j++)
                f[j] = 16'($urandom());
            if (inward) begin
                for (int j = 0; j < 3; j++) begin
                    v = int'($urandom_range(0, 32768)) - 16384;
                    f[j] = v[15:0];
                end
                f[3] = 16'($urandom_range(0, 'h1000));
            end
            write_cfg(t_reg_idx'(k), {f[3], f[2], f[1], f[0]});
        end
        for (int a = 0; a < 3; a++) begin
            f[a] = 16'($urandom());
            g[a] = 16'($urandom());
            if (inward) begin
                v = -int'($urandom_range('h100, 'h1000));
                f[a] = v[15:0];
                g[a] = 16'($urandom_range('h100, 'h1000));
            end
        end
        write_cfg(REG_BOX_MIN, {f[3], f[2], f[1], f[0]});
        write_cfg(REG_BOX_MAX, {f[3], g[2], g[1], g[0]});
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        board   = new();
        idle_on = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: zero planes never cull, frustum box is the origin
        send_prim(mk_prim(FUNC_POINT, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0));
        send_prim(mk_prim(FUNC_TRIANGLE, -32768, -32768, -32768, 32767, 0, -1,
                          -32768, 32767, 0));
        send_prim(mk_prim(FUNC_BOX, -1, -1, -1, 1, 1, 1, 0, 0, 0));
        send_prim(mk_prim(FUNC_BOX, 1, 1, 1, -1, -1, -1, 0, 0, 0));
        run_random(100, 4, 1'b0);
        drain();

        set_cube(-FBOX_HALF, FBOX_HALF);
        send_prim(mk_prim(FUNC_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_prim(mk_prim(FUNC_POINT, -1025, 0, 0, 0, 0, 0, 0, 0, 0));
        send_prim(mk_prim(FUNC_POINT, -1026, 0, 0, 0, 0, 0, 0, 0, 0));
        send_prim(mk_prim(FUNC_POINT, 1025, 0, 0, 0, 0, 0, 0, 0, 0));
        send_prim(mk_prim(FUNC_POINT, 0, 0, 1026, 0, 0, 0, 0, 0, 0));
        send_prim(mk_prim(FUNC_POINT, 0, 0, 0, 30000, 30000, 30000, 0, 0, 0));
        send_prim(mk_prim(FUNC_POINT, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0));
        send_prim(mk_prim(FUNC_POINT, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0));
        send_prim(mk_prim(FUNC_SEGMENT, -2000, 0, 0, 0, 0, 0, 0, 0, 0));
        send_prim(mk_prim(FUNC_SEGMENT, -2000, 0, 0, -1500, 0, 0, 0, 0, 0));
        send_prim(mk_prim(FUNC_SEGMENT, -2000, 0, 0, 2000, 0, 0, 0, 0, 0));
        send_prim(mk_prim(FUNC_TRIANGLE, 0, -1500, 0, 10, -1600, 5, -10, -1700, 0));
        send_prim(mk_prim(FUNC_TRIANGLE, 0, -1500, 0, 10, -1600, 5, 0, 0, 0));
        send_prim(mk_prim(FUNC_BOX, -100, -100, -100, 100, 100, 100, 0, 0, 0));
        send_prim(mk_prim(FUNC_BOX, -1500, -10, -10, -1200, 10, 10, 0, 0, 0));
        send_prim(mk_prim(FUNC_BOX, -1100, -10, -10, -900, 10, 10, 0, 0, 0));
        send_prim(mk_prim(FUNC_BOX, 970, -10, -10, 1000, 10, 10, 0, 0, 0));
        send_prim(mk_prim(FUNC_BOX, 960, -10, -10, 1000, 10, 10, 0, 0, 0));
        send_prim(mk_prim(FUNC_BOX, -1025, -10, -10, -1025, 10, 10, 0, 0, 0));
        send_prim(mk_prim(FUNC_BOX, 100, 100, 100, -100, -100, -100, 0, 0, 0));
        send_prim(mk_prim(FUNC_BOX, 2000, 0, 0, -2000, 0, 0, 0, 0, 0));
        send_prim(mk_prim(FUNC_BOX, -32768, -32768, -32768, 32767, 32767, 32767,
                          0, 0, 0));
        run_random(250, 'h600, 1'b0);
        drain();
        run_random(250, 'h600, 1'b0);
        drain();

        load_random_frustum(1'b1);
        run_random(400, 'h600, 1'b0);
        drain();

        load_random_frustum(1'b0);
        run_random(200, 32767, 1'b0);
        drain();

        write_cfg(REG_PLANE_A, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
        write_cfg(REG_PLANE_B, {16'h8000, 16'h8000, 16'h8000, 16'h8000});
        write_cfg(REG_PLANE_C, 64'h0);
        write_cfg(REG_PLANE_D, '1);
        write_cfg(REG_PLANE_E, {16'h0000, 16'h0000, 16'h7FFF, 16'h8000});
        write_cfg(REG_PLANE_F, {16'h8000, 16'h0000, 16'h0000, 16'h7FFF});
        write_cfg(REG_BOX_MIN, {16'h0000, 16'h8000, 16'h8000, 16'h8000});
        write_cfg(REG_BOX_MAX, {16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
        i_cfg_we <= 1'b0;
        run_random(150, 32767, 1'b0);
        drain();

        // inverted frustum box, full rate on both sides
        set_cube(FBOX_HALF, -FBOX_HALF);
        run_random(200, 'h600, 1'b1);
        drain();
        repeat (4) @(posedge i_clk);

        $display("Checked %0d result words: %0d boxes, %0d points, %0d segments, %0d triangles",
                 board.checked, sent_by_func[0], sent_by_func[1], sent_by_func[2],
                 sent_by_func[3]);
        $display("%0d visible, %0d culled, over reset, cube, random and extreme settings",
                 board.n_visible, board.checked - board.n_visible);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
design/fpc_pkg.sv
design/fpc_prep.sv
design/fpc_plane.sv
design/frustum_primitive_cull.sv
tb/tb_frustum_primitive_cull.sv
